// File: sv/shsr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shsr_pkg
// Shared types, constants and helpers for the half-step ramp sequencer.
// ---------------------------------------------------------------------------
package shsr_pkg;

   // Register map (index = byte address / 4)
   localparam int unsigned REG_COUNT = 5;
   localparam int unsigned ADDR_W    = 5;
   localparam logic [2:0] REG_RAMP_NUMERATOR = 3'd0;
   localparam logic [2:0] REG_START_RATE     = 3'd1;
   localparam logic [2:0] REG_MAX_RATE       = 3'd2;
   localparam logic [2:0] REG_RAMP_PERIOD    = 3'd3;
   localparam logic [2:0] REG_PULSE_WIDTH    = 3'd4;

   // Register reset values
   localparam logic [15:0] RAMP_NUMERATOR_RST = 16'd1000;
   localparam logic [7:0]  START_RATE_RST     = 8'd1;
   localparam logic [7:0]  MAX_RATE_RST       = 8'd100;
   localparam logic [15:0] RAMP_PERIOD_RST    = 16'd100;
   localparam logic [7:0]  PULSE_WIDTH_RST    = 8'd10;

   // Phase pattern constants
   localparam logic [7:0] PATTERN_ONE_RST = 8'h11;
   localparam logic [7:0] COIL_MASK       = 8'h0F;

   // Prior direction encoding: 0 forward, 1 reverse, 2 none
   localparam logic [1:0] DIR_NONE = 2'd2;

   // Divider geometry: 16-bit dividend, one quotient bit per cycle
   localparam int unsigned DIV_STEPS = 16;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [15:0] ramp_numerator;
      logic [7:0]  start_rate;
      logic [7:0]  max_rate;
      logic [15:0] ramp_period;
      logic [7:0]  pulse_width;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [3:0] {
      ST_IDLE       = 4'b0001,
      ST_DIVIDE     = 4'b0010,
      ST_EMIT_FIRST = 4'b0100,
      ST_EMIT_LAST  = 4'b1000
   } seq_state_type;

   // Forward step of a phase pattern (shift left, fold bit 3 down to 0)
   function automatic logic [7:0] rot_fwd(input logic [7:0] x);
      rot_fwd = {x[6:0], 1'b0} | {3'b000, x[7:3]};
   endfunction

   // Reverse step of a phase pattern (shift right, fold bits up by 3)
   function automatic logic [7:0] rot_rev(input logic [7:0] x);
      rot_rev = {1'b0, x[7:1]} | {x[4:0], 3'b000};
   endfunction

endpackage

// File: sv/shsr_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shsr_csr
// APB-style register file holding the ramp and pulse settings.
// ---------------------------------------------------------------------------
module shsr_csr import shsr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign reg_index = paddr[ADDR_W-1:2];
   assign wr_en     = psel & penable & pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write transaction
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_RAMP_NUMERATOR: cfg_in.ramp_numerator = pwdata[15:0];
            REG_START_RATE:     cfg_in.start_rate     = pwdata[7:0];
            REG_MAX_RATE:       cfg_in.max_rate       = pwdata[7:0];
            REG_RAMP_PERIOD:    cfg_in.ramp_period    = pwdata[15:0];
            REG_PULSE_WIDTH:    cfg_in.pulse_width    = pwdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_numerator <= RAMP_NUMERATOR_RST;
         cfg_ff.start_rate     <= START_RATE_RST;
         cfg_ff.max_rate       <= MAX_RATE_RST;
         cfg_ff.ramp_period    <= RAMP_PERIOD_RST;
         cfg_ff.pulse_width    <= PULSE_WIDTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (reg_index)
         REG_RAMP_NUMERATOR: prdata = {16'd0, cfg_ff.ramp_numerator};
         REG_START_RATE:     prdata = {24'd0, cfg_ff.start_rate};
         REG_MAX_RATE:       prdata = {24'd0, cfg_ff.max_rate};
         REG_RAMP_PERIOD:    prdata = {16'd0, cfg_ff.ramp_period};
         REG_PULSE_WIDTH:    prdata = {24'd0, cfg_ff.pulse_width};
         default:            prdata = 32'd0;
      endcase
   end

endmodule

// File: sv/shsr_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shsr_divider
// Restoring divider, 16-bit dividend by 8-bit divisor, one bit per cycle.
// ---------------------------------------------------------------------------
module shsr_divider import shsr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [15:0]    dividend,
   input  logic [7:0]     divisor,
   output div_status_type status,
   output logic [7:0]     quotient
);

   logic [15:0]          dq_ff, dq_in;
   logic [7:0]           rem_ff, rem_in;
   logic [7:0]           divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [8:0]           shifted;
   logic [8:0]           diff;
   logic                 fits;

   // One trial subtract per cycle; a zero divisor always fits, giving all ones
   assign shifted = {rem_ff, dq_ff[15]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         dq_in      = dividend;
         rem_in     = 8'd0;
         divisor_in = divisor;
         count_in   = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         dq_in    = {dq_ff[14:0], fits};
         rem_in   = fits ? diff[7:0] : shifted[7:0];
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = dq_ff[7:0];

endmodule

// File: sv/stepper_half_step_ramp_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stepper_half_step_ramp_sequencer
// Four-coil half-step sequencer with a divided-rate acceleration ramp.
// ---------------------------------------------------------------------------
// One transaction is worked at a time. A drive step without a ramp update
// and a pulse check go straight to emitting results; a drive step that
// updates the ramp first waits on the restoring divider, which produces one
// quotient bit per cycle (16 steps). A pulse check that is not due gives no
// result and leaves the input free. Results sit in an output register, so
// new transactions are taken while a result waits to be collected.
module stepper_half_step_ramp_sequencer import shsr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_opcode,
   input  logic              req_direction,
   input  logic [15:0]       req_ramp_ticks,
   input  logic              req_pulse_due,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_coil_pattern,
   output logic [7:0]        rsp_hold_time,
   output logic              rsp_clear_ramp_timer,
   output logic              rsp_last,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   cfg_type        cfg;
   div_status_type div_status;
   logic [7:0]     div_quotient;
   logic           div_start;

   seq_state_type  state_ff, state_in;
   logic [7:0]     pattern_one_ff, pattern_one_in;
   logic [7:0]     pattern_two_ff, pattern_two_in;
   logic           which_ff, which_in;
   logic [7:0]     step_rate_ff, step_rate_in;
   logic [7:0]     hold_delay_ff, hold_delay_in;
   logic [1:0]     prior_dir_ff, prior_dir_in;

   // pending result waiting for the output register
   logic [3:0]     pend_coil_ff, pend_coil_in;
   logic [7:0]     pend_hold_ff, pend_hold_in;
   logic           pend_clear_ff, pend_clear_in;
   logic           pend_last_ff, pend_last_in;

   // output register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [3:0]     rsp_coil_ff, rsp_coil_in;
   logic [7:0]     rsp_hold_ff, rsp_hold_in;
   logic           rsp_clear_ff, rsp_clear_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           accept;
   logic           out_free;
   logic           reload;
   logic           ramp;
   logic [7:0]     rate_eff;
   logic [7:0]     p1_step, p2_step;
   logic [7:0]     p2_next;
   logic [7:0]     coil_mix;
   logic [7:0]     sel_pat;
   logic [7:0]     sel_rot;
   logic [7:0]     p1_fwd;

   shsr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   shsr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cfg.ramp_numerator),
      .divisor  (rate_eff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   // Drive step datapath: reload on direction change, then rotate one pattern
   assign reload   = (prior_dir_ff != {1'b0, req_direction});
   assign rate_eff = reload ? cfg.start_rate : step_rate_ff;
   assign ramp     = (req_ramp_ticks > cfg.ramp_period);
   assign p2_step  = reload ? pattern_one_ff : pattern_two_ff;
   assign sel_pat  = which_ff ? p2_step : pattern_one_ff;
   assign sel_rot  = req_direction ? rot_rev(sel_pat) : rot_fwd(sel_pat);
   assign p1_step  = which_ff ? pattern_one_ff : sel_rot;
   assign p2_next  = which_ff ? sel_rot : p2_step;
   assign coil_mix = (p1_step | p2_next) & COIL_MASK;
   assign p1_fwd   = rot_fwd(pattern_one_ff);

   assign div_start = accept & ~req_opcode & ramp;

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      pattern_one_in = pattern_one_ff;
      pattern_two_in = pattern_two_ff;
      which_in       = which_ff;
      step_rate_in   = step_rate_ff;
      hold_delay_in  = hold_delay_ff;
      prior_dir_in   = prior_dir_ff;
      pend_coil_in   = pend_coil_ff;
      pend_hold_in   = pend_hold_ff;
      pend_clear_in  = pend_clear_ff;
      pend_last_in   = pend_last_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_coil_in    = rsp_coil_ff;
      rsp_hold_in    = rsp_hold_ff;
      rsp_clear_in   = rsp_clear_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !req_opcode) begin
               // drive step: advance pattern, capture result, ramp the rate
               pattern_one_in = p1_step;
               pattern_two_in = p2_next;
               which_in       = ~which_ff;
               prior_dir_in   = {1'b0, req_direction};
               pend_coil_in   = coil_mix[3:0];
               pend_hold_in   = hold_delay_ff;
               pend_clear_in  = ramp;
               pend_last_in   = 1'b1;
               if (ramp) begin
                  step_rate_in = (rate_eff > cfg.max_rate) ? cfg.max_rate
                                                           : rate_eff + 8'd1;
                  state_in     = ST_DIVIDE;
               end else begin
                  step_rate_in = rate_eff;
                  state_in     = ST_EMIT_FIRST;
               end
            end else if (accept && req_pulse_due) begin
               // keep-alive pulse: coils on for the pulse width, then off
               pattern_one_in = p1_fwd;
               pend_coil_in   = p1_fwd[3:0];
               pend_hold_in   = cfg.pulse_width;
               pend_clear_in  = 1'b0;
               pend_last_in   = 1'b0;
               state_in       = ST_EMIT_FIRST;
            end
         end
         ST_DIVIDE: begin
            // hold until the quotient is ready
            if (div_status.done) begin
               hold_delay_in = div_quotient;
               state_in      = ST_EMIT_FIRST;
            end
         end
         ST_EMIT_FIRST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_coil_in  = pend_coil_ff;
               rsp_hold_in  = pend_hold_ff;
               rsp_clear_in = pend_clear_ff;
               rsp_last_in  = pend_last_ff;
               state_in     = pend_last_ff ? ST_IDLE : ST_EMIT_LAST;
            end
         end
         ST_EMIT_LAST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_coil_in  = 4'd0;
               rsp_hold_in  = 8'd0;
               rsp_clear_in = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pattern_one_ff <= PATTERN_ONE_RST;
         pattern_two_ff <= 8'd0;
         which_ff       <= 1'b0;
         step_rate_ff   <= 8'd0;
         hold_delay_ff  <= 8'd0;
         prior_dir_ff   <= DIR_NONE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pattern_one_ff <= pattern_one_in;
         pattern_two_ff <= pattern_two_in;
         which_ff       <= which_in;
         step_rate_ff   <= step_rate_in;
         hold_delay_ff  <= hold_delay_in;
         prior_dir_ff   <= prior_dir_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_coil_ff  <= pend_coil_in;
      pend_hold_ff  <= pend_hold_in;
      pend_clear_ff <= pend_clear_in;
      pend_last_ff  <= pend_last_in;
      rsp_coil_ff   <= rsp_coil_in;
      rsp_hold_ff   <= rsp_hold_in;
      rsp_clear_ff  <= rsp_clear_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_coil_pattern     = rsp_coil_ff;
   assign rsp_hold_time        = rsp_hold_ff;
   assign rsp_clear_ramp_timer = rsp_clear_ff;
   assign rsp_last             = rsp_last_ff;

   // The divider only runs while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> (state_ff == ST_DIVIDE))
      else $error("divider busy outside divide state");

   // A drive step past the ramp period starts a division
   assert property (@(posedge clock) disable iff (reset)
      (accept && !req_opcode && ramp) |=> (state_ff == ST_DIVIDE) && div_status.busy)
      else $error("ramp update did not start the divider");

   // The first pulse result never asks for a ramp timer restart
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !rsp_clear_ramp_timer)
      else $error("pulse result flagged a ramp timer restart");

   // A not-due pulse check leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode && !req_pulse_due) |=> (state_ff == ST_IDLE))
      else $error("idle pulse check produced work");

endmodule
